### hdl/interval_arith_unit_assert.svh
// Assertion macros used by the interval ALU checker.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef INTERVAL_ARITH_UNIT_ASSERT_SVH
`define INTERVAL_ARITH_UNIT_ASSERT_SVH

// Same-cycle implication.
`define IAU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define IAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/iau_pkg.sv
// Shared types, constants and stage payloads of the interval ALU.
// No dependencies; imported by every module of the block.
`default_nettype none

package iau_pkg;

  localparam int DataWidth    = 32;
  localparam int FracBits     = 16;
  localparam int ShiftWidth   = 6;
  localparam int ProdWidth    = 2 * DataWidth;
  localparam int WideWidth    = ProdWidth - FracBits;
  localparam int TolWidth     = DataWidth + (2 ** ShiftWidth);
  localparam int InDataWidth  = 4 * DataWidth;
  localparam int OutDataWidth = ((4 * DataWidth + 3 + 7) / 8) * 8;
  localparam int OutPadWidth  = OutDataWidth - 4 * DataWidth - 3;

  localparam logic [ShiftWidth-1:0] TolShiftReset = ShiftWidth'(40);

  typedef enum logic [1:0] {
    ActAdd  = 2'd0,
    ActSub  = 2'd1,
    ActMul  = 2'd2,
    ActPass = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    PrInfInf,
    PrInfSup,
    PrSupInf,
    PrSupSup
  } prod_sel_e;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [DataWidth:0]   ext_t;
  typedef logic signed [ProdWidth-1:0] prod_t;
  typedef logic signed [WideWidth-1:0] wide_t;

  typedef struct packed {
    action_e   act;
    data_t     a_inf;
    data_t     a_sup;
    data_t     b_inf;
    data_t     b_sup;
    ext_t      lin_inf;
    ext_t      lin_sup;
    prod_sel_e lo_sel;
    prod_sel_e hi_sel;
    logic      straddle;
  } dec_t;

  typedef struct packed {
    action_e   act;
    ext_t      lin_inf;
    ext_t      lin_sup;
    prod_t     p_ii;
    prod_t     p_is;
    prod_t     p_si;
    prod_t     p_ss;
    prod_sel_e lo_sel;
    prod_sel_e hi_sel;
    logic      straddle;
  } mul_t;

  typedef struct packed {
    wide_t pre_inf;
    wide_t pre_sup;
  } rnd_t;

  typedef struct packed {
    data_t res_inf;
    data_t res_sup;
    logic  saturated;
  } clp_t;

  typedef struct packed {
    data_t res_inf;
    data_t res_sup;
    data_t res_width;
    data_t res_mid;
    logic  surely_positive;
    logic  surely_negative;
    logic  saturated;
  } res_t;

endpackage

`default_nettype wire

### hdl/iau_front.sv
// Input stage: sign-case decode for multiply, add/subtract of bounds.
// Depends on iau_pkg.
`default_nettype none

module iau_front import iau_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire action_e act_i,
  input  wire data_t   a_inf_i,
  input  wire data_t   a_sup_i,
  input  wire data_t   b_inf_i,
  input  wire data_t   b_sup_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output dec_t         out_o
);

  logic valid_q;
  dec_t data_q, data_d;
  logic a_pos, a_neg, b_pos, b_neg;

  assign a_pos = !a_inf_i[DataWidth-1];
  assign a_neg = !a_pos && ((a_sup_i == '0) || a_sup_i[DataWidth-1]);
  assign b_pos = !b_inf_i[DataWidth-1];
  assign b_neg = !b_pos && ((b_sup_i == '0) || b_sup_i[DataWidth-1]);

  always_comb begin
    data_d          = '0;
    data_d.act      = act_i;
    data_d.a_inf    = a_inf_i;
    data_d.a_sup    = a_sup_i;
    data_d.b_inf    = b_inf_i;
    data_d.b_sup    = b_sup_i;
    data_d.lo_sel   = PrInfInf;
    data_d.hi_sel   = PrSupSup;
    data_d.straddle = 1'b0;

    unique case (act_i)
      ActAdd: begin
        data_d.lin_inf = ext_t'(a_inf_i) + ext_t'(b_inf_i);
        data_d.lin_sup = ext_t'(a_sup_i) + ext_t'(b_sup_i);
      end
      ActSub: begin
        data_d.lin_inf = ext_t'(a_inf_i) - ext_t'(b_sup_i);
        data_d.lin_sup = ext_t'(a_sup_i) - ext_t'(b_inf_i);
      end
      default: begin
        data_d.lin_inf = ext_t'(a_inf_i);
        data_d.lin_sup = ext_t'(a_sup_i);
      end
    endcase

    if (a_pos) begin
      if (b_pos) begin
        data_d.lo_sel = PrInfInf; data_d.hi_sel = PrSupSup;
      end else if (b_neg) begin
        data_d.lo_sel = PrSupInf; data_d.hi_sel = PrInfSup;
      end else begin
        data_d.lo_sel = PrSupInf; data_d.hi_sel = PrSupSup;
      end
    end else if (a_neg) begin
      if (b_pos) begin
        data_d.lo_sel = PrInfSup; data_d.hi_sel = PrSupInf;
      end else if (b_neg) begin
        data_d.lo_sel = PrSupSup; data_d.hi_sel = PrInfInf;
      end else begin
        data_d.lo_sel = PrInfSup; data_d.hi_sel = PrInfInf;
      end
    end else begin
      if (b_pos) begin
        data_d.lo_sel = PrInfSup; data_d.hi_sel = PrSupSup;
      end else if (b_neg) begin
        data_d.lo_sel = PrSupInf; data_d.hi_sel = PrInfInf;
      end else begin
        data_d.straddle = 1'b1;
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

### hdl/iau_mult.sv
// Product stage: the four exact cross products of the operand bounds.
// Depends on iau_pkg.
`default_nettype none

module iau_mult import iau_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire dec_t in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output mul_t      out_o
);

  logic  valid_q;
  mul_t  data_q, data_d;
  data_t a_inf, a_sup, b_inf, b_sup;

  assign a_inf = in_i.a_inf;
  assign a_sup = in_i.a_sup;
  assign b_inf = in_i.b_inf;
  assign b_sup = in_i.b_sup;

  always_comb begin
    data_d          = '0;
    data_d.act      = in_i.act;
    data_d.lin_inf  = in_i.lin_inf;
    data_d.lin_sup  = in_i.lin_sup;
    data_d.lo_sel   = in_i.lo_sel;
    data_d.hi_sel   = in_i.hi_sel;
    data_d.straddle = in_i.straddle;
    data_d.p_ii     = prod_t'(a_inf) * prod_t'(b_inf);
    data_d.p_is     = prod_t'(a_inf) * prod_t'(b_sup);
    data_d.p_si     = prod_t'(a_sup) * prod_t'(b_inf);
    data_d.p_ss     = prod_t'(a_sup) * prod_t'(b_sup);
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

### hdl/iau_round.sv
// Bound select stage: floor lower/ceil upper product on multiply, else pass.
// Depends on iau_pkg.
`default_nettype none

module iau_round import iau_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire mul_t in_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output rnd_t      out_o
);

  localparam prod_t RoundBias = prod_t'({{(ProdWidth-FracBits){1'b0}}, {FracBits{1'b1}}});

  logic  valid_q;
  rnd_t  data_q, data_d;
  prod_t p_ii, p_is, p_si, p_ss;
  prod_t lo_fix, hi_fix, lo_prod, hi_prod, hi_bias;

  assign p_ii = in_i.p_ii;
  assign p_is = in_i.p_is;
  assign p_si = in_i.p_si;
  assign p_ss = in_i.p_ss;

  always_comb begin
    unique case (in_i.lo_sel)
      PrInfInf: lo_fix = p_ii;
      PrInfSup: lo_fix = p_is;
      PrSupInf: lo_fix = p_si;
      default:  lo_fix = p_ss;
    endcase
    unique case (in_i.hi_sel)
      PrInfInf: hi_fix = p_ii;
      PrInfSup: hi_fix = p_is;
      PrSupInf: hi_fix = p_si;
      default:  hi_fix = p_ss;
    endcase
  end

  assign lo_prod = in_i.straddle ? ((p_is < p_si) ? p_is : p_si) : lo_fix;
  assign hi_prod = in_i.straddle ? ((p_ii < p_ss) ? p_ss : p_ii) : hi_fix;
  assign hi_bias = hi_prod + RoundBias;

  always_comb begin
    if (in_i.act == ActMul) begin
      data_d.pre_inf = wide_t'(lo_prod >>> FracBits);
      data_d.pre_sup = wide_t'(hi_bias >>> FracBits);
    end else begin
      data_d.pre_inf = wide_t'(in_i.lin_inf);
      data_d.pre_sup = wide_t'(in_i.lin_sup);
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

### hdl/iau_finish.sv
// Saturation stage followed by the width, midpoint and sign-flag stage.
// Depends on iau_pkg.
`default_nettype none

module iau_finish import iau_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic [ShiftWidth-1:0] tol_shift_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire rnd_t                  in_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output res_t                       out_o
);

  localparam wide_t MaxW = wide_t'({1'b0, {(DataWidth-1){1'b1}}});
  localparam wide_t MinW = -MaxW - wide_t'(1);

  function automatic logic tol_test(ext_t near_bnd, ext_t other, logic [ShiftWidth-1:0] sh);
    logic [DataWidth:0]  mag;
    logic [TolWidth-1:0] shifted;
    mag     = near_bnd[DataWidth] ? $unsigned(-near_bnd) : $unsigned(near_bnd);
    shifted = TolWidth'(mag) << sh;
    return !other[DataWidth] && (other != '0) && (shifted < TolWidth'($unsigned(other)));
  endfunction

  logic  clp_valid_q, res_valid_q, clp_ready;
  clp_t  clp_q, clp_d;
  res_t  res_q, res_d;
  wide_t pre_inf, pre_sup;
  data_t ri, rs;
  ext_t  ri_x, rs_x, diff, sum;

  assign pre_inf = in_i.pre_inf;
  assign pre_sup = in_i.pre_sup;

  always_comb begin
    clp_d.saturated = 1'b0;
    if (pre_inf < MinW) begin
      clp_d.res_inf   = data_t'(MinW);
      clp_d.saturated = 1'b1;
    end else if (pre_inf > MaxW) begin
      clp_d.res_inf   = data_t'(MaxW);
      clp_d.saturated = 1'b1;
    end else begin
      clp_d.res_inf = data_t'(pre_inf);
    end
    if (pre_sup < MinW) begin
      clp_d.res_sup   = data_t'(MinW);
      clp_d.saturated = 1'b1;
    end else if (pre_sup > MaxW) begin
      clp_d.res_sup   = data_t'(MaxW);
      clp_d.saturated = 1'b1;
    end else begin
      clp_d.res_sup = data_t'(pre_sup);
    end
  end

  assign ri   = clp_q.res_inf;
  assign rs   = clp_q.res_sup;
  assign ri_x = ext_t'(ri);
  assign rs_x = ext_t'(rs);
  assign diff = rs_x - ri_x;
  assign sum  = rs_x + ri_x;

  always_comb begin
    res_d.res_inf         = ri;
    res_d.res_sup         = rs;
    res_d.res_width       = diff[DataWidth] ? '0 : diff[DataWidth-1:0];
    res_d.res_mid         = sum[DataWidth:1];
    res_d.surely_positive = (ri > 0) || tol_test(ri_x, rs_x, tol_shift_i);
    res_d.surely_negative = (rs < 0) || tol_test(rs_x, -ri_x, tol_shift_i);
    res_d.saturated       = clp_q.saturated;
  end

  assign clp_ready   = !res_valid_q || out_ready_i;
  assign in_ready_o  = !clp_valid_q || clp_ready;
  assign out_valid_o = res_valid_q;
  assign out_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clp_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        clp_valid_q <= in_valid_i;
      end
      if (clp_ready) begin
        res_valid_q <= clp_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      clp_q <= clp_d;
    end
    if (clp_ready && clp_valid_q) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

### hdl/interval_arith_unit.sv
// Interval ALU top level: add, subtract, multiply, pass on Q16.16 intervals.
// One register each for decode, products, bound select/round, saturate,
// width/mid/flags.
// Throughput: one word per cycle; each stage holds while its successor is full.
// Reset clears all stage valid bits and loads tolerance_shift with 40.
`default_nettype none

module interval_arith_unit import iau_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    s_axis_tvalid,
  output logic                         s_axis_tready,
  // a_inf, a_sup, b_inf, b_sup
  input  wire logic [InDataWidth-1:0]  s_axis_tdata,
  // action
  input  wire logic [1:0]              s_axis_tuser,
  output logic                         m_axis_tvalid,
  input  wire logic                    m_axis_tready,
  // res_inf, res_sup, res_width, res_mid, surely_positive, surely_negative,
  // saturated, zero pad
  output logic [OutDataWidth-1:0]      m_axis_tdata,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [ShiftWidth-1:0]   cfg_data_i
);

  logic [ShiftWidth-1:0] tol_shift_q;
  logic dec_valid, dec_ready, mul_valid, mul_ready, rnd_valid, rnd_ready;
  dec_t dec;
  mul_t mul;
  rnd_t rnd;
  res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_shift_q <= TolShiftReset;
    end else if (cfg_valid_i) begin
      tol_shift_q <= cfg_data_i;
    end
  end

  iau_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .act_i       (action_e'(s_axis_tuser)),
    .a_inf_i     (data_t'(s_axis_tdata[DataWidth-1:0])),
    .a_sup_i     (data_t'(s_axis_tdata[2*DataWidth-1:DataWidth])),
    .b_inf_i     (data_t'(s_axis_tdata[3*DataWidth-1:2*DataWidth])),
    .b_sup_i     (data_t'(s_axis_tdata[4*DataWidth-1:3*DataWidth])),
    .out_valid_o (dec_valid),
    .out_ready_i (dec_ready),
    .out_o       (dec)
  );

  iau_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dec_valid),
    .in_ready_o  (dec_ready),
    .in_i        (dec),
    .out_valid_o (mul_valid),
    .out_ready_i (mul_ready),
    .out_o       (mul)
  );

  iau_round u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mul_valid),
    .in_ready_o  (mul_ready),
    .in_i        (mul),
    .out_valid_o (rnd_valid),
    .out_ready_i (rnd_ready),
    .out_o       (rnd)
  );

  iau_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tol_shift_i (tol_shift_q),
    .in_valid_i  (rnd_valid),
    .in_ready_o  (rnd_ready),
    .in_i        (rnd),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {{OutPadWidth{1'b0}}, res.saturated, res.surely_negative,
                         res.surely_positive, res.res_mid, res.res_width,
                         res.res_sup, res.res_inf};

endmodule

`default_nettype wire

### hdl/iau_checker.sv
// Port-level checker for interval_arith_unit, bound to the top level.
// Depends on iau_pkg and interval_arith_unit_assert.svh.
`default_nettype none
`include "interval_arith_unit_assert.svh"

module iau_checker import iau_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    s_axis_tready,
  input wire logic                    m_axis_tvalid,
  input wire logic                    m_axis_tready,
  input wire logic [OutDataWidth-1:0] m_axis_tdata
);

  localparam data_t MaxV = data_t'({1'b0, {(DataWidth-1){1'b1}}});
  localparam data_t MinV = data_t'({1'b1, {(DataWidth-1){1'b0}}});

  data_t res_inf, res_sup;
  logic  surely_positive, saturated;

  assign res_inf         = data_t'(m_axis_tdata[DataWidth-1:0]);
  assign res_sup         = data_t'(m_axis_tdata[2*DataWidth-1:DataWidth]);
  assign surely_positive = m_axis_tdata[4*DataWidth];
  assign saturated       = m_axis_tdata[4*DataWidth+2];

  `IAU_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")

  `IAU_ASSERT_NOW(a_full_only_on_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready, "input blocked without output stall")

  `IAU_ASSERT_NOW(a_sat_at_limit, m_axis_tvalid && saturated, (res_inf == MaxV) || (res_inf == MinV) || (res_sup == MaxV) || (res_sup == MinV), "saturated without a bound at a limit")

  `IAU_ASSERT_NOW(a_pos_flag, m_axis_tvalid && (res_inf > 0), surely_positive, "positive lower bound without surely_positive")

endmodule

bind interval_arith_unit iau_checker u_iau_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### tb/interval_arith_unit_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for interval_arith_unit: add, subtract, multiply and pass
// on Q16.16 intervals, with tolerant sign flags, under random idling and back-pressure.
// Depends on iau_pkg for widths, the action codes and the result struct.

module interval_arith_unit_tb;
  import iau_pkg::*;

  localparam int    ClkPeriod     = 10;
  localparam int    CycleLimit    = 200000;
  localparam int    ItemsPerPhase = 125;
  localparam int    HoldCycles    = 300;
  localparam int    DrainCycles   = 10;
  localparam data_t MaxVal        = 32'sh7FFF_FFFF;
  localparam data_t MinVal        = 32'sh8000_0000;
  localparam data_t One           = 32'sh0001_0000;
  localparam longint MaxBound     = (64'sd1 <<< (DataWidth - 1)) - 1;
  localparam longint MinBound     = -(64'sd1 <<< (DataWidth - 1));

  class interval_scoreboard;
    res_t                  pending_results[$];
    logic [ShiftWidth-1:0] tol_shift;
    int unsigned           accepted;
    int unsigned           checked;
    int unsigned           errors;
    int unsigned           saturations;

    function new();
      tol_shift   = TolShiftReset;
      accepted    = 0;
      checked     = 0;
      errors      = 0;
      saturations = 0;
    endfunction

    function data_t clamp(longint v, inout bit sat);
      if (v > MaxBound) begin
        sat = 1'b1;
        return MaxVal;
      end
      if (v < MinBound) begin
        sat = 1'b1;
        return MinVal;
      end
      return data_t'(v);
    endfunction

    function longint prod(data_t x, data_t y);
      return longint'(x) * longint'(y);
    endfunction

    function bit negligible(logic signed [127:0] small_bound, logic signed [127:0] other);
      logic signed [127:0] mag;
      mag = (small_bound < 0) ? -small_bound : small_bound;
      return (mag << tol_shift) < other;
    endfunction

    function res_t interval_result(action_e act, data_t a_inf, data_t a_sup,
                                   data_t b_inf, data_t b_sup);
      res_t                r;
      bit                  sat;
      bit                  a_pos, a_neg, b_pos, b_neg;
      longint              lo, hi, p1, p2, span, total;
      data_t               ri, rs;
      logic signed [127:0] wi, ws;
      sat = 1'b0;
      lo  = 0;
      hi  = 0;
      ri  = a_inf;
      rs  = a_sup;
      case (act)
        ActAdd: begin
          ri = clamp(longint'(a_inf) + longint'(b_inf), sat);
          rs = clamp(longint'(a_sup) + longint'(b_sup), sat);
        end
        ActSub: begin
          ri = clamp(longint'(a_inf) - longint'(b_sup), sat);
          rs = clamp(longint'(a_sup) - longint'(b_inf), sat);
        end
        ActMul: begin
          a_pos = (a_inf >= 0);
          a_neg = !a_pos && (a_sup <= 0);
          b_pos = (b_inf >= 0);
          b_neg = !b_pos && (b_sup <= 0);
          if (a_pos) begin
            if (b_pos) begin
              lo = prod(a_inf, b_inf); hi = prod(a_sup, b_sup);
            end else if (b_neg) begin
              lo = prod(a_sup, b_inf); hi = prod(a_inf, b_sup);
            end else begin
              lo = prod(a_sup, b_inf); hi = prod(a_sup, b_sup);
            end
          end else if (a_neg) begin
            if (b_pos) begin
              lo = prod(a_inf, b_sup); hi = prod(a_sup, b_inf);
            end else if (b_neg) begin
              lo = prod(a_sup, b_sup); hi = prod(a_inf, b_inf);
            end else begin
              lo = prod(a_inf, b_sup); hi = prod(a_inf, b_inf);
            end
          end else begin
            if (b_pos) begin
              lo = prod(a_inf, b_sup); hi = prod(a_sup, b_sup);
            end else if (b_neg) begin
              lo = prod(a_sup, b_inf); hi = prod(a_inf, b_inf);
            end else begin
              p1 = prod(a_inf, b_sup);
              p2 = prod(a_sup, b_inf);
              lo = (p1 < p2) ? p1 : p2;
              p1 = prod(a_inf, b_inf);
              p2 = prod(a_sup, b_sup);
              hi = (p1 < p2) ? p2 : p1;
            end
          end
          // floor the lower bound, ceil the upper bound
          ri = clamp(lo >>> FracBits, sat);
          rs = clamp((hi + ((64'sd1 <<< FracBits) - 1)) >>> FracBits, sat);
        end
        default: ;
      endcase
      span  = longint'(rs) - longint'(ri);
      total = (longint'(ri) + longint'(rs)) >>> 1;
      wi    = ri;
      ws    = rs;
      r.res_inf         = ri;
      r.res_sup         = rs;
      r.res_width       = (span < 0) ? '0 : data_t'(span);
      r.res_mid         = data_t'(total);
      r.surely_positive = (ri > 0) || negligible(wi, ws);
      r.surely_negative = (rs < 0) || negligible(ws, -wi);
      r.saturated       = sat;
      return r;
    endfunction

    function void note_input(logic [1:0] kind, logic [InDataWidth-1:0] word);
      pending_results.push_back(interval_result(action_e'(kind), word[31:0], word[63:32],
                                                word[95:64], word[127:96]));
      accepted++;
    endfunction

    function bit field_matches(string name, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) begin
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, got_v);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function void check_result(logic [OutDataWidth-1:0] word);
      res_t want;
      bit   ok;
      if (pending_results.size() == 0) begin
        $display("%0t: result word %h arrived with nothing pending", $time, word);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      checked++;
      if (want.saturated) saturations++;
      ok = 1'b1;
      ok = ok & field_matches("res_inf", want.res_inf, word[31:0]);
      ok = ok & field_matches("res_sup", want.res_sup, word[63:32]);
      ok = ok & field_matches("res_width", want.res_width, word[95:64]);
      ok = ok & field_matches("res_mid", want.res_mid, word[127:96]);
      ok = ok & field_matches("surely_positive", 32'(want.surely_positive), 32'(word[128]));
      ok = ok & field_matches("surely_negative", 32'(want.surely_negative), 32'(word[129]));
      ok = ok & field_matches("saturated", 32'(want.saturated), 32'(word[130]));
      if (!ok) errors++;
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [InDataWidth-1:0]  s_axis_tdata  = '0;
  logic [1:0]              s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OutDataWidth-1:0] m_axis_tdata;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [ShiftWidth-1:0]   cfg_data_i    = '0;

  bit                 idle_on  = 1'b1;
  bit                 stall_on = 1'b1;
  bit                 hold_req = 1'b0;
  int unsigned        cycles   = 0;
  interval_scoreboard sb;

  interval_arith_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  initial begin
    while (cycles < CycleLimit) @(posedge clk_i) cycles++;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end
  end

  // hold off the receiver for a long stretch on request, otherwise stall at random while stall_on
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end
      m_axis_tready <= !stall_on || ($urandom_range(99) >= 18);
    end
  end

  task automatic send_item(action_e act, data_t a_inf, data_t a_sup,
                           data_t b_inf, data_t b_sup);
    while (idle_on && $urandom_range(99) < 18) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {b_sup, b_inf, a_sup, a_inf};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_tol(logic [ShiftWidth-1:0] shift);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= shift;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.tol_shift = shift;
  endtask

  function automatic data_t rand_bound();
    case ($urandom_range(9))
      0:       return MaxVal;
      1:       return MinVal;
      2:       return '0;
      3, 4:    return data_t'($urandom_range(32'h80000)) - data_t'(32'h40000);
      5:       return data_t'($urandom_range(30)) - 15;
      default: return data_t'($urandom());
    endcase
  endfunction

  // mostly ordered bounds, now and then an inverted interval
  task automatic rand_interval(output data_t lo_b, output data_t hi_b);
    data_t t;
    lo_b = rand_bound();
    hi_b = rand_bound();
    if (lo_b > hi_b && $urandom_range(9) != 0) begin
      t    = lo_b;
      lo_b = hi_b;
      hi_b = t;
    end
  endtask

  task automatic run_random(int n);
    data_t a_inf, a_sup, b_inf, b_sup;
    repeat (n) begin
      rand_interval(a_inf, a_sup);
      rand_interval(b_inf, b_sup);
      send_item(action_e'($urandom_range(3)), a_inf, a_sup, b_inf, b_sup);
    end
  endtask

  initial begin
    int shift_plan[5];
    sb = new();
    shift_plan    = '{0, 63, 0, 0, 40};
    shift_plan[2] = $urandom_range(12, 1);
    shift_plan[3] = $urandom_range(63, 0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(ActAdd, MaxVal, MaxVal, 1, MaxVal);
    send_item(ActAdd, MinVal, MinVal, -1, MinVal);
    send_item(ActSub, MinVal, MaxVal, -1, 1);
    send_item(ActSub, 32'sh0001_8000, 32'sh0002_8000, 32'sh0000_8000, One);
    send_item(ActMul, One, 2 * One, 3 * One, 4 * One);
    send_item(ActMul, One, 2 * One, -4 * One, -One);
    send_item(ActMul, One, 2 * One, -One, 3 * One);
    send_item(ActMul, -2 * One, -One, One, 3 * One);
    send_item(ActMul, -2 * One, 0, -3 * One, -One);
    send_item(ActMul, -2 * One, -One, -One, One);
    send_item(ActMul, -One, 2 * One, 0, 3 * One);
    send_item(ActMul, -One, 2 * One, -3 * One, -One);
    send_item(ActMul, -2 * One, 3 * One, -5 * One, One);
    send_item(ActMul, MinVal, MinVal, MinVal, MinVal);
    send_item(ActMul, MinVal, MaxVal, MinVal, MaxVal);
    send_item(ActMul, 1, 1, 1, 1);
    send_item(ActMul, -1, -1, 1, 3);
    send_item(ActMul, 2 * One, -One, One, -2 * One);
    send_item(ActAdd, One, -One, 0, 0);
    send_item(ActPass, 5 * One, -5 * One, 0, 0);
    send_item(ActPass, 0, 5, MaxVal, MinVal);
    send_item(ActPass, -5, 0, 0, 0);
    send_item(ActPass, 0, 0, MinVal, MaxVal);
    send_item(ActPass, -1, MaxVal, 0, 0);
    send_item(ActPass, MinVal, MaxVal, 0, 0);
    run_random(ItemsPerPhase);

    for (int p = 0; p < 5; p++) begin
      drain();
      write_tol(ShiftWidth'(shift_plan[p]));
      idle_on  = (p != 1);
      stall_on = (p != 1);
      if (p == 2) hold_req = 1'b1;
      run_random(ItemsPerPhase);
    end

    drain();
    repeat (DrainCycles) @(posedge clk_i);
    $display("%0d interval words over 6 tolerance settings (0, 63, 40 and random ones)",
             sb.accepted);
    $display("%0d results compared, %0d of them saturated, one %0d-cycle receiver hold",
             sb.checked, sb.saturations, HoldCycles);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
